// ===== sv/tdrgb_pkg.sv =====
package tdrgb_pkg;

  localparam int ACCEL_W = 16;
  localparam int GAIN_W  = 12;
  localparam int PERIOD_W = 16;
  localparam int LEVEL_W = 14;
  localparam int STEP_W  = 11;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_TOP      = 2'd2;

  localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST = 16'd100;
  localparam logic [GAIN_W-1:0]   ACCEL_GAIN_RST    = 12'd400;
  localparam logic [LEVEL_W-1:0]  FADE_TOP_RST      = 14'd1000;

  // floor(x / 10) == (x * 52429) >> 19 for every x below 43690
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [STEP_W-1:0]  step_t;

  // |a| * gain >> 16, magnitude of -32768 is 32768
  function automatic step_t up_step(input logic signed [ACCEL_W-1:0] a,
                                    input logic [GAIN_W-1:0] gain);
    logic [ACCEL_W-1:0]        mag;
    logic [ACCEL_W+GAIN_W-1:0] prod;
    mag  = a[ACCEL_W-1] ? ACCEL_W'(-a) : ACCEL_W'(a);
    prod = (ACCEL_W+GAIN_W)'(mag) * (ACCEL_W+GAIN_W)'(gain);
    return prod[16 +: STEP_W];
  endfunction

  // down-ramp step: level / 10 + 1
  function automatic step_t down_step(input level_t lvl);
    logic [LEVEL_W+15:0] prod;
    logic [STEP_W-1:0]   q;
    prod = (LEVEL_W+16)'(lvl) * (LEVEL_W+16)'(DIV10_MUL);
    q    = prod[DIV10_SHIFT +: STEP_W];
    return q + STEP_W'(1);
  endfunction

endpackage

// ===== sv/tilt_driven_rgb_fade_engine_core.sv =====
// Tilt-driven RGB fade engine. Each input word is one tick carrying an
// accelerometer sample (x, y, z); each tick yields exactly one output word with
// the three duty levels, the ramp direction and an update flag. A prescaler
// counts ticks and every update_period-th tick (every tick when the period is
// 0) applies a fade step: ramping up, each level grows by |accel| * accel_gain
// >> 16; if any level would pass fade_top the adds are dropped, the steps become
// level/10 + 1 and the ramp turns down; ramping down, levels shrink by their
// step and clamp at 0, and the ramp turns up once all three would go negative.
// Throughput is one word per clock: the state update is a single pass of logic
// (two small multiplies per channel) from the input word to the output register,
// so the block takes a new word every cycle the output register is free or
// being drained. Config writes (cfg_we/cfg_index/cfg_data) take effect on the
// next tick; unknown indexes are ignored.
module tilt_driven_rgb_fade_engine_core
  import tdrgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // duty_red[13:0], duty_green[27:14],
                                           // duty_blue[41:28], zero fill[47:42]
  output logic [1:0]            m_tuser    // ramping_down[0], was_update[1]
);

  // config registers
  logic [PERIOD_W-1:0] update_period;
  logic [GAIN_W-1:0]   accel_gain;
  level_t              fade_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_period <= UPDATE_PERIOD_RST;
      accel_gain    <= ACCEL_GAIN_RST;
      fade_top      <= FADE_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPDATE_PERIOD: update_period <= cfg_data[PERIOD_W-1:0];
        REG_ACCEL_GAIN:    accel_gain    <= cfg_data[GAIN_W-1:0];
        REG_FADE_TOP:      fade_top      <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // fade state; a level only grows to at most fade_top, a 14-bit value, so 14 bits hold it
  logic [PERIOD_W-1:0] tick_count, tick_count_next;
  level_t              level [3];
  level_t              level_next [3];
  step_t               step [3];
  step_t               step_next [3];
  logic                direction_down, direction_down_next;
  logic                upd;

  logic signed [ACCEL_W-1:0] accel [3];
  step_t                     up_s [3];
  step_t                     dn_s [3];
  logic [LEVEL_W:0]          sum  [3];
  logic [2:0]                over, neg;
  level_t                    diff [3];
  logic [PERIOD_W-1:0]       tick_inc;

  logic accept, out_take;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  assign accel[0] = s_tdata[15:0];
  assign accel[1] = s_tdata[31:16];
  assign accel[2] = s_tdata[47:32];

  always_comb begin
    tick_inc = tick_count + PERIOD_W'(1);
    upd      = (tick_inc >= update_period);
    tick_count_next = upd ? '0 : tick_inc;

    for (int c = 0; c < 3; c++) begin
      up_s[c] = up_step(accel[c], accel_gain);
      dn_s[c] = down_step(level[c]);
      sum[c]  = {1'b0, level[c]} + (LEVEL_W+1)'(up_s[c]);
      over[c] = sum[c] > {1'b0, fade_top};
      neg[c]  = LEVEL_W'(step[c]) > level[c];
      diff[c] = level[c] - LEVEL_W'(step[c]);
    end

    for (int c = 0; c < 3; c++) begin
      level_next[c] = level[c];
      step_next[c]  = step[c];
    end
    direction_down_next = direction_down;

    if (upd) begin
      if (!direction_down) begin
        if (|over) begin
          // overshoot: keep levels, derive down steps from them
          for (int c = 0; c < 3; c++) step_next[c] = dn_s[c];
          direction_down_next = 1'b1;
        end else begin
          for (int c = 0; c < 3; c++) begin
            step_next[c]  = up_s[c];
            level_next[c] = sum[c][LEVEL_W-1:0];
          end
        end
      end else begin
        for (int c = 0; c < 3; c++) level_next[c] = neg[c] ? '0 : diff[c];
        if (&neg) direction_down_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      direction_down <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        level[c] <= '0;
        step[c]  <= '0;
      end
    end else if (accept) begin
      tick_count     <= tick_count_next;
      direction_down <= direction_down_next;
      for (int c = 0; c < 3; c++) begin
        level[c] <= level_next[c];
        step[c]  <= step_next[c];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (out_take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'd0, level_next[2], level_next[1], level_next[0]};
      m_tuser <= {upd, direction_down_next};
    end
  end

endmodule

// ===== tb/tdrgb_fade_checker.sv =====
`timescale 1ns / 1ps

// Watches the config port and both stream channels of the fade engine,
// predicts every output word and compares it field by field.
module tdrgb_fade_checker
  import tdrgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [47:0]           s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [47:0]           m_tdata,   // duty_red[13:0], duty_green[27:14],
                                           // duty_blue[41:28], zero fill[47:42]
  input  logic [1:0]            m_tuser,   // ramping_down[0], was_update[1]
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic   was_update;
    logic   ramping_down;
    level_t blue;
    level_t green;
    level_t red;
  } duty_word_t;

  // shadow registers
  logic [PERIOD_W-1:0] period;
  logic [GAIN_W-1:0]   gain;
  level_t              top;

  // fade state
  logic [PERIOD_W-1:0] tick_cnt;
  logic [14:0]         lvl [3];
  step_t               stp [3];
  logic                going_down;

  duty_word_t duty_q [$];

  // |a| * gain >> 16, magnitude of -32768 kept as 32768
  function automatic step_t rise_step(input logic [15:0] a, input logic [GAIN_W-1:0] g);
    logic [16:0] mag;
    logic [28:0] prod;
    mag  = a[15] ? 17'h10000 - 17'(a) : 17'(a);
    prod = 29'(mag) * 29'(g);
    return prod[26:16];
  endfunction

  task automatic advance_fade(input logic [47:0] word);
    logic [15:0]         accel [3];
    logic [16:0]         sum [3];
    logic [16:0]         diff;
    logic [PERIOD_W-1:0] next_cnt;
    logic [2:0]          neg;
    logic                upd;
    logic                hit;
    duty_word_t          w;
    for (int i = 0; i < 3; i++) accel[i] = word[16*i +: 16];
    next_cnt = tick_cnt + 16'd1;
    upd      = next_cnt >= period;
    tick_cnt = upd ? '0 : next_cnt;
    if (upd && !going_down) begin
      hit = 1'b0;
      for (int i = 0; i < 3; i++) begin
        stp[i] = rise_step(accel[i], gain);
        sum[i] = 17'(lvl[i]) + 17'(stp[i]);
        if (sum[i] > 17'(top)) hit = 1'b1;
      end
      if (hit) begin
        // overshoot: keep levels, derive down steps from them
        for (int i = 0; i < 3; i++) stp[i] = step_t'(lvl[i] / 15'd10 + 15'd1);
        going_down = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) lvl[i] = sum[i][14:0];
      end
    end else if (upd) begin
      for (int i = 0; i < 3; i++) begin
        diff   = {2'b00, lvl[i]} - {6'b0, stp[i]};
        neg[i] = diff[16];
        lvl[i] = neg[i] ? 15'd0 : diff[14:0];
      end
      if (&neg) going_down = 1'b0;
    end
    w.red          = lvl[0][LEVEL_W-1:0];
    w.green        = lvl[1][LEVEL_W-1:0];
    w.blue         = lvl[2][LEVEL_W-1:0];
    w.ramping_down = going_down;
    w.was_update   = upd;
    duty_q.push_back(w);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    duty_word_t w;
    if (rst) begin
      period     = UPDATE_PERIOD_RST;
      gain       = ACCEL_GAIN_RST;
      top        = FADE_TOP_RST;
      tick_cnt   = '0;
      going_down = 1'b0;
      for (int i = 0; i < 3; i++) begin
        lvl[i] = '0;
        stp[i] = '0;
      end
      duty_q.delete();
      failures = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_UPDATE_PERIOD: period = cfg_data[PERIOD_W-1:0];
          REG_ACCEL_GAIN:    gain   = cfg_data[GAIN_W-1:0];
          REG_FADE_TOP:      top    = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) advance_fade(s_tdata);
      if (m_tvalid && m_tready) begin
        if (duty_q.size() == 0) begin
          $display("%0t: output word with none expected, actual %h/%b",
                   $time, m_tdata, m_tuser);
          failures++;
        end else begin
          w = duty_q.pop_front();
          check_field("duty_red", w.red, m_tdata[13:0]);
          check_field("duty_green", w.green, m_tdata[27:14]);
          check_field("duty_blue", w.blue, m_tdata[41:28]);
          check_field("ramping_down", w.ramping_down, m_tuser[0]);
          check_field("was_update", w.was_update, m_tuser[1]);
        end
      end
      pending <= duty_q.size();
    end
  end

endmodule

// ===== tb/tilt_driven_rgb_fade_engine_core_test.sv =====
`timescale 1ns / 1ps

// Fade engine test: a short directed run over the sample extremes and the
// prescaler / top corner cases, then random phases of ticks, each phase under
// a fresh register setting written while the engine is drained.
module tilt_driven_rgb_fade_engine_core_test;
  import tdrgb_pkg::*;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int RANDOM_TICKS = 1650;
  localparam int CYCLE_LIMIT  = 500000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata = '0;    // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [47:0]           m_tdata;         // duty_red[13:0], duty_green[27:14],
                                          // duty_blue[41:28], zero fill[47:42]
  logic [1:0]            m_tuser;         // ramping_down[0], was_update[1]

  int failures;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  int sent = 0;

  // receiver stall pattern state
  logic [7:0] rx_cycle = '0;
  int         rx_mode = 0;
  int         stall_left = 0;

  always #4 clk = ~clk;

  tilt_driven_rgb_fade_engine_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  tdrgb_fade_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .failures  (failures),
    .pending   (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: whenever the 8-bit rx_cycle counter wraps, pick a mode - always ready,
  // random 3-in-4 ready, or occasional stalls whose length is drawn at random.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle == 8'd0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          m_tready   <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 15);
        end
      end
    endcase
  end

  // One tick word. Sender runs in bursts; between bursts it drops tvalid
  // for a random gap (often none, so long back-to-back runs happen too).
  task automatic send_tick(input logic [15:0] ax, input logic [15:0] ay,
                           input logic [15:0] az);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {az, ay, ax};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Stop sending and let every expected word come back.
  task automatic drain;
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // cfg_we stays high; caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] period, input logic [15:0] gain,
                          input logic [15:0] top);
    drain();
    write_reg(REG_UPDATE_PERIOD, period);
    write_reg(REG_ACCEL_GAIN, gain);
    write_reg(REG_FADE_TOP, top);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 16'($urandom()));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_accel();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      4, 5: begin
        v = 16'($urandom_range(0, 400));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  initial begin
    int phase_len;
    logic [15:0] period, gain, top;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: period 100, so these are plain prescaler ticks
    send_tick(16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h7FFF, 16'h8000, 16'hFFFF);

    // zero period: every tick updates; full gain gives the largest steps
    set_regs(16'd0, 16'd4095, 16'd16000);
    send_tick(16'h7FFF, 16'h8000, 16'h8000);
    send_tick(16'h8000, 16'h7FFF, 16'h7FFF);
    send_tick(16'h8001, 16'h0001, 16'h8000);

    // top lowered under the current levels: next up-ramp update turns down
    drain();
    write_reg(REG_FADE_TOP, 16'd1000);
    write_reg(REG_SPARE, 16'hFFFF);
    cfg_we <= 1'b0;
    send_tick(16'h0001, 16'hFFFF, 16'h0000);

    // period lowered below the running count: next tick updates
    set_regs(16'd200, 16'd0, 16'd16000);
    repeat (5) send_tick(pick_accel(), pick_accel(), pick_accel());
    drain();
    write_reg(REG_UPDATE_PERIOD, 16'd3);
    cfg_we <= 1'b0;
    send_tick(16'h1234, 16'hEDCB, 16'h0F0F);

    // ramp down until all three go negative and the ramp turns up
    set_regs(16'd0, 16'd4095, 16'd16000);
    repeat (10) send_tick(pick_accel(), pick_accel(), pick_accel());

    // random phases
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      case ($urandom_range(0, 9))
        0: period = 16'd0;
        1: period = 16'd65535;
        2, 3: period = 16'($urandom_range(5, 40));
        4: period = 16'($urandom_range(1, 65535));
        default: period = 16'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 5))
        0: gain = 16'd0;
        1: gain = 16'd4095;
        2: gain = 16'($urandom_range(0, 4095));
        default: gain = 16'($urandom_range(200, 1500));
      endcase
      case ($urandom_range(0, 5))
        0: top = 16'd1;
        1: top = 16'd16000;
        2: top = 16'($urandom_range(1, 16000));
        default: top = 16'($urandom_range(500, 4000));
      endcase
      set_regs(period, gain, top);
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) send_tick(pick_accel(), pick_accel(), pick_accel());
    end

    drain();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tdrgb_pkg.sv
sv/tilt_driven_rgb_fade_engine_core.sv
tb/tdrgb_fade_checker.sv
tb/tilt_driven_rgb_fade_engine_core_test.sv
